### rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared constants, register map and result record for the RIP response
// parser.
// ----------------------------------------------------------------------------
package rrp_pkg;

    // packet layout
    localparam logic [2:0] HEADER_BYTES   = 3'd4;
    localparam logic [4:0] MAX_ENTRIES    = 5'd25;
    localparam int         ENTRY_STORED   = 19;     // entry bytes held before the last one
    localparam logic [4:0] ENTRY_LAST_POS = 5'd19;

    localparam logic [2:0] HDR_POS_COMMAND = 3'd0;
    localparam logic [2:0] HDR_POS_VERSION = 3'd1;

    // configuration register map
    localparam int         APB_ADDR_W       = 3;
    localparam logic       REG_SOURCE_ADDR  = 1'b0;
    localparam logic       REG_EXPECTED_VER = 1'b1;
    localparam logic [7:0] EXPECTED_VER_RST = 8'd2;

    localparam int TDATA_W = 176;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SHORT   = 2'd1,
        ERR_VERSION = 2'd2
    } err_code_t;

    typedef struct packed {
        logic [31:0] route_metric;
        logic [31:0] next_hop;
        logic [31:0] mask;
        logic [31:0] destination;
        logic [15:0] tag;
        logic [15:0] family_id;
        logic [4:0]  entries_total;
        logic [7:0]  command;
        err_code_t   fault_code;
        logic        packet_done;
        logic        has_entry;
    } result_t;

endpackage

### rtl/core/rip_response_parser.sv
// ----------------------------------------------------------------------------
// rip_response_parser
// Parses a RIP packet one byte per beat, checks the version, assembles
// 20-byte route entries and reports status on the last byte.
// ----------------------------------------------------------------------------
// results enter the output register, or the skid stage if it is full and held;
// throughput: one byte per cycle while the skid stage is empty; the output
//   register plus a one-deep skid stage keep s_tready high while a single result waits
// reset: synchronous active-low aresetn clears parse state, both output
//   stages and the registers (source address 0, expected version 2)
module rip_response_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream: tdata = data_byte[7:0]; tlast = last_byte
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic                             s_tlast,
    // result stream: tdata = fault_code[1:0], command[9:2], entries_total[14:10],
    // family_id[30:15], tag[46:31], destination[78:47], mask[110:79],
    // next_hop[142:111], route_metric[174:143], zero pad[175]
    // tuser = has_entry[0]; tlast = packet_done
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rrp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import rrp_pkg::*;

    // configuration registers
    logic [31:0] src_addr_reg;
    logic [7:0]  exp_ver_reg;

    // parse state
    logic [2:0] hdr_pos_reg, hdr_pos_next;
    logic [7:0] command_reg, command_next;
    logic       ver_bad_reg, ver_bad_next;
    logic [4:0] entry_pos_reg, entry_pos_next;
    logic [4:0] entry_cnt_reg, entry_cnt_next;
    logic [7:0] entry_sh_reg [ENTRY_STORED];

    // output stages
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic    accept, pop, push, store_byte, emit;
    logic [31:0] nh_raw;
    result_t res_next;

    assign pready   = 1'b1;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= '0;
            exp_ver_reg  <= EXPECTED_VER_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_SOURCE_ADDR:  src_addr_reg <= pwdata;
                REG_EXPECTED_VER: exp_ver_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SOURCE_ADDR:  prdata = src_addr_reg;
            REG_EXPECTED_VER: prdata = {24'd0, exp_ver_reg};
            default:          prdata = '0;
        endcase
    end

    // byte decode
    always_comb begin
        hdr_pos_next   = hdr_pos_reg;
        command_next   = command_reg;
        ver_bad_next   = ver_bad_reg;
        entry_pos_next = entry_pos_reg;
        entry_cnt_next = entry_cnt_reg;
        store_byte     = 1'b0;
        emit           = 1'b0;

        if (hdr_pos_reg < HEADER_BYTES) begin
            if (hdr_pos_reg == HDR_POS_COMMAND) begin
                command_next = s_tdata;
            end else if (hdr_pos_reg == HDR_POS_VERSION) begin
                ver_bad_next = (s_tdata != exp_ver_reg);
            end
            hdr_pos_next = hdr_pos_reg + 3'd1;
        end else if (!ver_bad_reg && entry_cnt_reg < MAX_ENTRIES) begin
            if (entry_pos_reg < ENTRY_LAST_POS) begin
                store_byte     = 1'b1;
                entry_pos_next = entry_pos_reg + 5'd1;
            end else begin
                emit           = 1'b1;
                entry_pos_next = '0;
                entry_cnt_next = entry_cnt_reg + 5'd1;
            end
        end

        nh_raw = {entry_sh_reg[12], entry_sh_reg[13], entry_sh_reg[14], entry_sh_reg[15]};

        res_next               = '0;
        res_next.has_entry     = emit;
        res_next.packet_done   = s_tlast;
        res_next.command       = command_next;
        res_next.entries_total = entry_cnt_next;
        if (s_tlast) begin
            if (hdr_pos_next < HEADER_BYTES) begin
                res_next.fault_code = ERR_SHORT;
            end else if (ver_bad_next) begin
                res_next.fault_code = ERR_VERSION;
            end else begin
                res_next.fault_code = ERR_NONE;
            end
        end
        if (emit) begin
            res_next.family_id    = {entry_sh_reg[0], entry_sh_reg[1]};
            res_next.tag          = {entry_sh_reg[2], entry_sh_reg[3]};
            res_next.destination  = {entry_sh_reg[4], entry_sh_reg[5],
                                     entry_sh_reg[6], entry_sh_reg[7]};
            res_next.mask         = {entry_sh_reg[8], entry_sh_reg[9],
                                     entry_sh_reg[10], entry_sh_reg[11]};
            res_next.next_hop     = (nh_raw == '0) ? src_addr_reg : nh_raw;
            res_next.route_metric = {entry_sh_reg[16], entry_sh_reg[17],
                                     entry_sh_reg[18], s_tdata};
        end

        push = accept && (emit || s_tlast);
    end

    // parse state, cleared at the end of every packet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg   <= '0;
            command_reg   <= '0;
            ver_bad_reg   <= 1'b0;
            entry_pos_reg <= '0;
            entry_cnt_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                hdr_pos_reg   <= '0;
                command_reg   <= '0;
                ver_bad_reg   <= 1'b0;
                entry_pos_reg <= '0;
                entry_cnt_reg <= '0;
            end else begin
                hdr_pos_reg   <= hdr_pos_next;
                command_reg   <= command_next;
                ver_bad_reg   <= ver_bad_next;
                entry_pos_reg <= entry_pos_next;
                entry_cnt_reg <= entry_cnt_next;
            end
        end
    end

    // entry bytes shift in, oldest at index 0
    always_ff @(posedge aclk) begin
        if (accept && store_byte) begin
            for (int i = 0; i < ENTRY_STORED - 1; i++) begin
                entry_sh_reg[i] <= entry_sh_reg[i+1];
            end
            entry_sh_reg[ENTRY_STORED-1] <= s_tdata;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.packet_done;
    assign m_tuser  = out_reg.has_entry;
    assign m_tdata  = {1'b0,
                       out_reg.route_metric,
                       out_reg.next_hop,
                       out_reg.mask,
                       out_reg.destination,
                       out_reg.tag,
                       out_reg.family_id,
                       out_reg.entries_total,
                       out_reg.command,
                       out_reg.fault_code};

    // checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output stage is empty");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_cnt_reg <= MAX_ENTRIES)
        else $error("entry count beyond limit");

    a_entry_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_pos_reg <= ENTRY_LAST_POS && hdr_pos_reg <= HEADER_BYTES)
        else $error("position counter out of range");

    a_bad_ver_no_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        ver_bad_reg |-> (entry_pos_reg == '0 && entry_cnt_reg == '0))
        else $error("entries collected on a bad version packet");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (hdr_pos_reg == '0 && entry_cnt_reg == '0 && !ver_bad_reg))
        else $error("packet state not cleared after last byte");

endmodule

### tb/rip_route_checker.sv
// ----------------------------------------------------------------------------
// rip_route_checker
// Watches the byte stream, the result stream and register writes of the RIP
// response parser, predicts every result from its own copy of the parse state
// and compares the results in arrival order, field by field.
// ----------------------------------------------------------------------------
module rip_route_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rrp_pkg::TDATA_W-1:0]       m_tdata,
    input  logic [0:0]                        m_tuser,
    input  logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rrp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                results_waiting,
    output int                                packets_seen,
    output int                                entries_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import rrp_pkg::*;

    logic [31:0] source_addr;
    logic [7:0]  wanted_version;
    logic [2:0]  header_pos;
    logic [7:0]  command_byte;
    logic        version_wrong;
    logic [4:0]  entry_pos;
    logic [4:0]  entry_cnt;
    logic [7:0]  entry_buf [ENTRY_STORED];

    result_t     expected_routes [$];

    function automatic void clear_packet();
        header_pos    = '0;
        command_byte  = '0;
        version_wrong = 1'b0;
        entry_pos     = '0;
        entry_cnt     = '0;
    endfunction

    // one byte through the parse state, queuing the result it causes if any
    function automatic void parse_byte(input logic [7:0] value, input logic is_last);
        result_t r;
        logic    emitted;
        r       = '0;
        emitted = 1'b0;
        if (header_pos < HEADER_BYTES) begin
            if (header_pos == HDR_POS_COMMAND) begin
                command_byte = value;
            end else if (header_pos == HDR_POS_VERSION) begin
                version_wrong = (value != wanted_version);
            end
            header_pos = header_pos + 3'd1;
        end else if (!version_wrong && entry_cnt < MAX_ENTRIES) begin
            if (entry_pos < ENTRY_LAST_POS) begin
                entry_buf[entry_pos] = value;
                entry_pos = entry_pos + 5'd1;
            end else begin
                r.family_id    = {entry_buf[0], entry_buf[1]};
                r.tag          = {entry_buf[2], entry_buf[3]};
                r.destination  = {entry_buf[4], entry_buf[5], entry_buf[6], entry_buf[7]};
                r.mask         = {entry_buf[8], entry_buf[9], entry_buf[10], entry_buf[11]};
                r.next_hop     = {entry_buf[12], entry_buf[13], entry_buf[14], entry_buf[15]};
                if (r.next_hop == '0) begin
                    r.next_hop = source_addr;
                end
                r.route_metric = {entry_buf[16], entry_buf[17], entry_buf[18], value};
                entry_pos = '0;
                entry_cnt = entry_cnt + 5'd1;
                emitted   = 1'b1;
            end
        end
        if (emitted || is_last) begin
            r.has_entry     = emitted;
            r.packet_done   = is_last;
            r.command       = command_byte;
            r.entries_total = entry_cnt;
            if (!is_last) begin
                r.fault_code = ERR_NONE;
            end else if (header_pos < HEADER_BYTES) begin
                // a short packet wins over a bad version
                r.fault_code = ERR_SHORT;
            end else if (version_wrong) begin
                r.fault_code = ERR_VERSION;
            end else begin
                r.fault_code = ERR_NONE;
            end
            expected_routes.insert(expected_routes.size(), r);
        end
        if (is_last) begin
            clear_packet();
        end
    endfunction

    function automatic string route_text(input result_t r);
        return $sformatf({"entry=%0b done=%0b err=%0d cmd=%h total=%0d fam=%h tag=%h",
                          " dst=%h mask=%h hop=%h metric=%h"},
                         r.has_entry, r.packet_done, r.fault_code, r.command,
                         r.entries_total, r.family_id, r.tag, r.destination, r.mask,
                         r.next_hop, r.route_metric);
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_route();
        result_t got;
        result_t want;
        string   diffs;
        got               = '0;
        got.has_entry     = m_tuser[0];
        got.packet_done   = m_tlast;
        got.fault_code    = err_code_t'(m_tdata[1:0]);
        got.command       = m_tdata[9:2];
        got.entries_total = m_tdata[14:10];
        got.family_id     = m_tdata[30:15];
        got.tag           = m_tdata[46:31];
        got.destination   = m_tdata[78:47];
        got.mask          = m_tdata[110:79];
        got.next_hop      = m_tdata[142:111];
        got.route_metric  = m_tdata[174:143];
        if (expected_routes.size() == 0) begin
            note_failure({"result beat with nothing expected: ", route_text(got)});
            return;
        end
        want  = expected_routes.pop_front();
        diffs = "";
        if (got.has_entry !== want.has_entry)         diffs = {diffs, " has_entry"};
        if (got.packet_done !== want.packet_done)     diffs = {diffs, " packet_done"};
        if (got.fault_code !== want.fault_code)       diffs = {diffs, " fault_code"};
        if (got.command !== want.command)             diffs = {diffs, " command"};
        if (got.entries_total !== want.entries_total) diffs = {diffs, " entries_total"};
        if (got.family_id !== want.family_id)         diffs = {diffs, " family_id"};
        if (got.tag !== want.tag)                     diffs = {diffs, " tag"};
        if (got.destination !== want.destination)     diffs = {diffs, " destination"};
        if (got.mask !== want.mask)                   diffs = {diffs, " mask"};
        if (got.next_hop !== want.next_hop)           diffs = {diffs, " next_hop"};
        if (got.route_metric !== want.route_metric)   diffs = {diffs, " route_metric"};
        if (diffs != "") begin
            note_failure({"mismatch in", diffs, "\n  expected ", route_text(want),
                          "\n  actual   ", route_text(got)});
        end
        if (want.packet_done) packets_seen++;
        if (want.has_entry) entries_seen++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            source_addr    = '0;
            wanted_version = EXPECTED_VER_RST;
            clear_packet();
            expected_routes.delete();
            mismatches     = 0;
            packets_seen   = 0;
            entries_seen   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SOURCE_ADDR) begin
                    source_addr = pwdata;
                end else begin
                    wanted_version = pwdata[7:0];
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_route();
            end
        end
        results_waiting = expected_routes.size();
    end

endmodule

### tb/tb_rip_response_parser.sv
// ----------------------------------------------------------------------------
// tb_rip_response_parser
// Drives RIP packets byte by byte into the response parser under several
// register settings and traffic patterns; the route checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rip_response_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rrp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_SOURCE  = {REG_SOURCE_ADDR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_VERSION = {REG_EXPECTED_VER, 2'b00};
    localparam int PHASE_BYTES    = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int mismatches;
    int results_waiting;
    int packets_seen;
    int entries_seen;

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;
    int          bytes_sent     = 0;
    int          phase_bytes    = 0;
    logic [7:0]  cur_version    = EXPECTED_VER_RST;
    logic [7:0]  frame_bytes [$];

    always #1 aclk = ~aclk;

    rip_response_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rip_route_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_waiting (results_waiting),
        .packets_seen    (packets_seen),
        .entries_seen    (entries_seen)
    );

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    task automatic add_byte(input logic [7:0] value);
        frame_bytes.insert(frame_bytes.size(), value);
    endtask

    task automatic push_word(input logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endtask

    // sender pause: nothing offered until every result is back and the block settles
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [31:0] src, input logic [7:0] ver);
        wait_drained();
        write_reg(ADDR_SOURCE, src);
        // upper bits are junk the register must drop
        write_reg(ADDR_VERSION, {24'($urandom), ver});
        cur_version = ver;
    endtask

    task automatic send_packet(input int n_entries, input int tail_len, input bit bad_version);
        logic [7:0] entry [20];
        add_byte(8'($urandom_range(255)));
        add_byte(bad_version ? cur_version ^ 8'($urandom_range(1, 255)) : cur_version);
        add_byte(8'($urandom_range(255)));
        add_byte(8'($urandom_range(255)));
        for (int e = 0; e < n_entries; e++) begin
            foreach (entry[k]) entry[k] = 8'($urandom_range(255));
            if ($urandom_range(99) < 35) begin
                for (int k = 12; k < 16; k++) entry[k] = 8'h00;
            end
            foreach (entry[k]) add_byte(entry[k]);
        end
        for (int k = 0; k < tail_len; k++) add_byte(8'($urandom_range(255)));
        phase_bytes += frame_bytes.size();
        send_frame();
    endtask

    task automatic send_short(input int len);
        add_byte(8'($urandom_range(255)));
        if (len >= 2) begin
            add_byte($urandom_range(1) ? cur_version
                                       : cur_version ^ 8'($urandom_range(1, 255)));
        end
        if (len >= 3) add_byte(8'($urandom_range(255)));
        phase_bytes += len;
        send_frame();
    endtask

    initial begin
        int pick;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single byte packet, short packet carrying a bad version,
        // then one entry with a zero next hop ending right on the entry
        add_byte(8'hFF);
        send_frame();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h00);
        send_frame();
        push_word({8'h02, EXPECTED_VER_RST, 16'h0000});
        push_word(32'h0002_FFFF);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'h0000_0000);
        push_word(32'h0000_0010);
        send_frame();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(32'hFFFF_FFFF, 8'd0);
                1: configure(32'($urandom), 8'd255);
                2: configure(32'h0000_0000, 8'($urandom));
                default: configure(32'($urandom), EXPECTED_VER_RST);
            endcase
            case (ph)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
                default: begin send_gap_pct = 23; recv_stall_pct = 23; end
            endcase
            phase_bytes = 0;
            if (ph == 0) begin
                // long downstream hold-off while bytes keep coming
                hold_request = 1'b1;
                send_packet(2, 0, 1'b0);
                repeat (10) send_short(1);
                wait_drained();
            end
            if (ph == 2) begin
                // more entries than the limit, plus a partial one behind them
                send_packet(MAX_ENTRIES + 1, 7, 1'b0);
            end
            while (phase_bytes < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_short($urandom_range(1, 3));
                end else if (pick < 18) begin
                    send_packet($urandom_range(0, 2), $urandom_range(0, 19), 1'b1);
                end else begin
                    send_packet($urandom_range(0, 3),
                                $urandom_range(1) ? 0 : $urandom_range(1, 19), 1'b0);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("sent %0d bytes; checked %0d packets and %0d route entries",
                 bytes_sent, packets_seen, entries_seen);
        $display("covered short, bad-version, partial and over-limit packets across four"
                 , " traffic patterns and five register settings");
        if (results_waiting != 0) begin
            $display("%0d expected results never arrived", results_waiting);
        end
        if (mismatches == 0 && results_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rrp_pkg.sv
rtl/core/rip_response_parser.sv
tb/rip_route_checker.sv
tb/tb_rip_response_parser.sv
